// ===== hdl/integer_day_linear_resampler_macros.svh =====
// Assertion macros for the integer-day linear resampler checker.
// Included by the checker file; needs clk and rst_n in scope.
`ifndef INTEGER_DAY_LINEAR_RESAMPLER_MACROS_SVH
`define INTEGER_DAY_LINEAR_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define IDLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define IDLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idlr_pkg.sv =====
// Shared widths and defaults for the integer-day linear resampler.
// No dependencies; used by every RTL module and the checker.
`timescale 1ns / 1ps

package idlr_pkg;

  localparam int TIME_W        = 32;  // sample time, unsigned fixed point
  localparam int VAL_W         = 32;  // sample value, signed Q16.16
  localparam int DAY_W         = 17;  // day field on the result channel
  localparam int WGT_W         = 32;  // interpolation weight, Q1.31 in (0, 1]
  localparam int PROD_W        = VAL_W + WGT_W;

  localparam int MAX_GAP_DEF   = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_TDATA_W    = 64;  // time + value
  localparam int OUT_TDATA_W   = 56;  // day + value, zero padded to bytes

  // One quotient bit per divider step
  localparam int DIV_STEPS     = WGT_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

endpackage

// ===== hdl/integer_day_linear_resampler.sv =====
// Integer-day linear resampler top level: sequencer, series state, output register.
// Uses idlr_pkg, idlr_div and idlr_blend.
//
// Usage:
//   Input channel in_*: one sample per transfer, time and value in in_tdata, in_tlast
//   marks the final sample of a series. Result channel out_*: one whole-day point per
//   transfer, out_tlast on the final point caused by a sample, out_tuser flags a gap
//   longer than MAX_GAP days (only MAX_GAP points are then given).
//   Rate: one sample at a time. Each interpolated day waits for the serial divider (one weight
//   bit per cycle, 32 bits) and then the registered multiply/round stage. in_tready is high
//   only while no sample is being worked on.
//   Output: a result register holds each point; the next sample may be taken while
//   the final point of the previous one still waits. When out_tready is low the
//   sequencer holds its next point until the register is free; nothing is dropped.
//   Reset: synchronous, active low; clears the series state (no previous sample)
//   and empties the result register.
`timescale 1ns / 1ps

module integer_day_linear_resampler
  import idlr_pkg::*;
#(
  parameter int MAX_GAP   = MAX_GAP_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample_time, [63:32] sample_value
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [16:0] day, [48:17] day_value, rest zero
  output logic                   out_tlast,  // last_of_run
  output logic                   out_tuser   // gap_overflow
);

  localparam int ND_W  = TIME_W - FRAC_BITS + 1;   // day count incl. one past the end
  localparam int CNT_W = $clog2(MAX_GAP + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_PUT   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // series state
  logic [TIME_W-1:0]       prev_time_r, prev_time_nxt;
  logic signed [VAL_W-1:0] prev_value_r, prev_value_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic [ND_W-1:0]         next_day_r, next_day_nxt;

  // current sample and run bookkeeping
  logic [TIME_W-1:0]       cur_time_r, cur_time_nxt;
  logic signed [VAL_W-1:0] cur_value_r, cur_value_nxt;
  logic                    cur_last_r, cur_last_nxt;
  logic [ND_W-1:0]         d_r, d_nxt;
  logic [CNT_W-1:0]        days_left_r, days_left_nxt;
  logic                    tail_pend_r, tail_pend_nxt;
  logic                    ovf_r, ovf_nxt;

  // pending point
  logic [DAY_W-1:0]        res_day_r, res_day_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic                    res_last_r, res_last_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]        out_day_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_last_r, out_ovf_r;
  logic                    out_load, out_free;

  // input decode
  logic [TIME_W-1:0]       in_time;
  logic signed [VAL_W-1:0] in_val;
  logic [ND_W-1:0]         fl, fl_p1, gap;
  logic                    gap_big, in_frac;

  // shared units
  logic                    div_start, div_done;
  logic [TIME_W-1:0]       div_num, div_den;
  logic [WGT_W-1:0]        div_quo;
  logic [ND_W+FRAC_BITS-1:0] d_scaled;
  logic                    blend_start, blend_done;
  logic signed [VAL_W-1:0] blend_q;

  assign in_time = in_tdata[TIME_W-1:0];
  assign in_val  = in_tdata[TIME_W+VAL_W-1:TIME_W];
  assign fl      = ND_W'(in_time >> FRAC_BITS);
  assign fl_p1   = fl + 1'b1;
  assign gap     = fl_p1 - next_day_r;
  assign gap_big = gap > ND_W'(MAX_GAP);
  assign in_frac = in_time[FRAC_BITS-1:0] != '0;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // weight operands: day position and span since the previous sample
  assign d_scaled = {d_r, {FRAC_BITS{1'b0}}};
  assign div_num  = d_scaled[TIME_W-1:0] - prev_time_r;
  assign div_den  = cur_time_r - prev_time_r;

  idlr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  idlr_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (blend_start),
    .wgt        (div_quo),
    .prev_value (prev_value_r),
    .cur_value  (cur_value_r),
    .done       (blend_done),
    .result     (blend_q)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    prev_time_nxt  = prev_time_r;
    prev_value_nxt = prev_value_r;
    have_prev_nxt  = have_prev_r;
    next_day_nxt   = next_day_r;
    cur_time_nxt   = cur_time_r;
    cur_value_nxt  = cur_value_r;
    cur_last_nxt   = cur_last_r;
    d_nxt          = d_r;
    days_left_nxt  = days_left_r;
    tail_pend_nxt  = tail_pend_r;
    ovf_nxt        = ovf_r;
    res_day_nxt    = res_day_r;
    res_val_nxt    = res_val_r;
    res_last_nxt   = res_last_r;
    div_start      = 1'b0;
    blend_start    = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_time_nxt  = in_time;
          cur_value_nxt = in_val;
          cur_last_nxt  = in_tlast;
          ovf_nxt       = 1'b0;
          days_left_nxt = '0;
          tail_pend_nxt = in_tlast && in_frac;
          if (!have_prev_r) begin
            // first sample of a series: floor day with its own value
            res_day_nxt  = DAY_W'(fl);
            res_val_nxt  = in_val;
            res_last_nxt = !(in_tlast && in_frac);
            next_day_nxt = fl_p1;
            state_nxt    = S_PUT;
          end else if (fl_p1 > next_day_r) begin
            d_nxt         = next_day_r;
            next_day_nxt  = fl_p1;
            ovf_nxt       = gap_big;
            days_left_nxt = gap_big ? CNT_W'(MAX_GAP) : CNT_W'(gap);
            state_nxt     = S_START;
          end else if (in_tlast && in_frac) begin
            res_day_nxt   = DAY_W'(next_day_r);
            res_val_nxt   = in_val;
            res_last_nxt  = 1'b1;
            tail_pend_nxt = 1'b0;
            state_nxt     = S_PUT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          blend_start = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        if (blend_done) begin
          res_day_nxt   = DAY_W'(d_r);
          res_val_nxt   = blend_q;
          res_last_nxt  = (days_left_r == CNT_W'(1)) && !tail_pend_r;
          d_nxt         = d_r + 1'b1;
          days_left_nxt = days_left_r - 1'b1;
          state_nxt     = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (days_left_r != '0) begin
            state_nxt = S_START;
          end else if (tail_pend_r) begin
            // trailing point: ceiling day with the last value
            res_day_nxt   = DAY_W'(next_day_r);
            res_val_nxt   = cur_value_r;
            res_last_nxt  = 1'b1;
            tail_pend_nxt = 1'b0;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (cur_last_r) begin
          prev_time_nxt  = '0;
          prev_value_nxt = '0;
          have_prev_nxt  = 1'b0;
          next_day_nxt   = '0;
        end else begin
          prev_time_nxt  = cur_time_r;
          prev_value_nxt = cur_value_r;
          have_prev_nxt  = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_time_r  <= '0;
      prev_value_r <= '0;
      have_prev_r  <= 1'b0;
      next_day_r   <= '0;
      days_left_r  <= '0;
      tail_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_time_r  <= prev_time_nxt;
      prev_value_r <= prev_value_nxt;
      have_prev_r  <= have_prev_nxt;
      next_day_r   <= next_day_nxt;
      days_left_r  <= days_left_nxt;
      tail_pend_r  <= tail_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_time_r  <= cur_time_nxt;
    cur_value_r <= cur_value_nxt;
    cur_last_r  <= cur_last_nxt;
    d_r         <= d_nxt;
    ovf_r       <= ovf_nxt;
    res_day_r   <= res_day_nxt;
    res_val_r   <= res_val_nxt;
    res_last_r  <= res_last_nxt;
    if (out_load) begin
      out_day_r  <= res_day_r;
      out_val_r  <= res_val_r;
      out_last_r <= res_last_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DAY_W - VAL_W){1'b0}}, out_val_r, out_day_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ===== hdl/idlr_div.sv =====
// Serial restoring divider: weight = floor(num * 2^31 / den), one bit per cycle.
// Requires 0 < num <= den. Depends on idlr_pkg.
`timescale 1ns / 1ps

module idlr_div
  import idlr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [WGT_W-1:0]  quo
);

  logic [TIME_W:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]  den_r, den_nxt;
  logic [WGT_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic               ge;
  logic [TIME_W:0]    diff;
  logic [TIME_W:0]    keep;

  // compare-subtract step shared by every quotient bit
  assign diff = rem_r - {1'b0, den_r};
  assign ge   = rem_r >= {1'b0, den_r};
  assign keep = ge ? diff : rem_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WGT_W-2:0], ge};
      rem_nxt = {keep[TIME_W-1:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/idlr_blend.sv =====
// Blend stage: prev + round(delta * w / 2^31), half away from zero.
// Three registered steps: magnitude, multiply, round and add. Depends on idlr_pkg.
`timescale 1ns / 1ps

module idlr_blend
  import idlr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [WGT_W-1:0]        wgt,
  input  logic signed [VAL_W-1:0] prev_value,
  input  logic signed [VAL_W-1:0] cur_value,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  logic signed [VAL_W:0]   delta;
  logic [VAL_W:0]          delta_abs;
  logic [VAL_W-1:0]        mag_r;
  logic                    neg_r, neg2_r;
  logic [WGT_W-1:0]        wgt_r;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W:0]         rnd;
  logic [VAL_W-1:0]        r_mag;
  logic [VAL_W+1:0]        base;
  logic [VAL_W+1:0]        sum;
  logic signed [VAL_W-1:0] res_r;
  logic                    v1_r, v2_r, done_r;

  // difference of the two samples is exact in 33 bits
  assign delta     = {cur_value[VAL_W-1], cur_value} - {prev_value[VAL_W-1], prev_value};
  assign delta_abs = delta[VAL_W] ? (~delta + 1'b1) : delta;

  // round the Q1.31 product back to value scale
  assign rnd   = {1'b0, prod_r} + (PROD_W + 1)'(64'd1 << (WGT_W - 2));
  assign r_mag = rnd[VAL_W + WGT_W - 2 : WGT_W - 1];
  assign base  = {{2{prev_value[VAL_W-1]}}, prev_value};
  assign sum   = neg2_r ? (base - {2'b00, r_mag}) : (base + {2'b00, r_mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= delta_abs[VAL_W-1:0];
      neg_r <= delta[VAL_W];
      wgt_r <= wgt;
    end
    if (v1_r) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(wgt_r);
      neg2_r <= neg_r;
    end
    if (v2_r) begin
      res_r <= sum[VAL_W-1:0];
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== hdl/idlr_checker.sv =====
// Port-level checker for the integer-day linear resampler, bound to the top level.
// Uses idlr_pkg and integer_day_linear_resampler_macros.svh.
`timescale 1ns / 1ps
`include "integer_day_linear_resampler_macros.svh"

module idlr_checker
  import idlr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  // a stalled point stays put
  `IDLR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // one sample at a time: busy right after a transfer
  `IDLR_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "ready stayed high after input transfer")

  // when idle, a waiting point can only be the final one of its sample
  `IDLR_ASSERT_NOW(a_idle_tail, in_tready && out_tvalid, out_tlast, "idle with a non-final result pending")

  // a non-final point leaves while the sample is still in work
  `IDLR_ASSERT_NOW(a_mid_run_busy, out_tvalid && out_tready && !out_tlast, !in_tready, "ready during a run")

endmodule

bind integer_day_linear_resampler idlr_checker u_idlr_checker (.*);
